FILE: rtl/core/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, types and helper functions of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

   // Map geometry
   localparam int FRAME_COUNT = 1024;
   localparam int WORD_BITS   = 32;
   localparam int MAP_WORDS   = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int FRM_W       = ADDR_W + BIT_W;
   localparam int TAIL_BITS   = FRAME_COUNT % WORD_BITS;

   // Request and result fields
   localparam int BYTE_ADDR_W = 32;
   localparam int FRAME_SHIFT = 12;
   localparam int SPAN_W      = BYTE_ADDR_W - FRAME_SHIFT + 1;
   localparam int INDEX_W     = 10;
   localparam int FIDX_W      = (FRM_W > INDEX_W) ? FRM_W : INDEX_W;

   // Request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_MARK  = 1'b1;

   // Result codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_READ,
      ST_MODIFY,
      ST_DONE
   } state_type;

   // Bits of a map word that stand for real frames
   function automatic word_type frame_mask(input logic [ADDR_W-1:0] addr);
      word_type m;
      m = '1;
      if ((TAIL_BITS != 0) && (addr == ADDR_W'(MAP_WORDS - 1))) begin
         m = ~('1 << TAIL_BITS);
      end
      return m;
   endfunction

   // Lowest clear bit of a word that is known not to be full
   function automatic logic [BIT_W-1:0] first_zero(input word_type w);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!w[b]) begin
            r = BIT_W'(b);
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/fba_if.sv
// ----------------------------------------------------------------------------
// fba_if
// Valid/ready channels of the frame bitmap allocator: requests and results.
// ----------------------------------------------------------------------------
interface fba_req_if;
   import fba_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [BYTE_ADDR_W-1:0] range_start;
   logic [BYTE_ADDR_W-1:0] range_end;

   modport source (output valid, req_type, range_start, range_end, input ready);
   modport sink   (input valid, req_type, range_start, range_end, output ready);
endinterface

interface fba_rsp_if;
   import fba_pkg::*;

   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] frame_index;
   logic               status;

   modport source (output valid, frame_index, status, input ready);
   modport sink   (input valid, frame_index, status, output ready);
endinterface

FILE: rtl/core/frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit page frame allocator over a used/free bitmap held in one RAM.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each bitmap word visited is read from the
// RAM in ST_READ, then modified and written back in ST_MODIFY; ST_PREP sets up
// the request and ST_DONE hands over the result. An allocate scans from word 0
// up to the first word with a free frame, and reports out of memory when the
// last word is full; a mark-range goes from setup straight to the result when
// the range starts beyond the map. Every word has a valid bit cleared by reset,
// so the map reads as all free at once and needs no clearing pass. A new request
// is taken while a result still waits.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator (
   input logic        clock,
   input logic        reset,
   fba_req_if.sink    req_port,
   fba_rsp_if.source  rsp_port
);
   import fba_pkg::*;

   // Sequencer state
   state_type                state_ff, state_in;
   logic                     op_ff, op_in;
   logic [BYTE_ADDR_W-1:0]   start_ff, start_in;
   logic [BYTE_ADDR_W-1:0]   end_ff, end_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [FRM_W-1:0]         first_ff, first_in;
   logic [FRM_W-1:0]         last_ff, last_in;
   logic [INDEX_W-1:0]       res_index_ff, res_index_in;
   logic                     res_status_ff, res_status_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic                     rsp_status_ff, rsp_status_in;

   // Bitmap RAM and per-word valid bits
   word_type                 map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0]     map_valid_ff;
   word_type                 mem_q_ff;
   logic                     valid_q_ff;
   logic                     mem_we;
   word_type                 mem_wdata;

   // Datapath helpers
   word_type                 cur_word;
   word_type                 avail_word;
   word_type                 range_mask;
   logic [BIT_W-1:0]         free_bit;
   logic [BIT_W-1:0]         lo_bit;
   logic [BIT_W-1:0]         hi_bit;
   logic [FIDX_W-1:0]        frame_wide;
   logic [SPAN_W-2:0]        first_frame;
   logic [BYTE_ADDR_W-1:0]   span_bytes;
   logic [SPAN_W-1:0]        last_frame;
   logic                     slot_free;

   assign cur_word    = valid_q_ff ? mem_q_ff : '0;
   assign avail_word  = cur_word | ~frame_mask(addr_ff);
   assign free_bit    = first_zero(avail_word);
   assign frame_wide  = FIDX_W'({addr_ff, free_bit});
   assign first_frame = start_ff[BYTE_ADDR_W-1:FRAME_SHIFT];
   assign span_bytes  = end_ff - start_ff;
   assign last_frame  = {1'b0, first_frame} + {1'b0, span_bytes[BYTE_ADDR_W-1:FRAME_SHIFT]};
   assign lo_bit      = (addr_ff == first_ff[FRM_W-1:BIT_W]) ? first_ff[BIT_W-1:0] : '0;
   assign hi_bit      = (addr_ff == last_ff[FRM_W-1:BIT_W]) ? last_ff[BIT_W-1:0]
                                                            : BIT_W'(WORD_BITS - 1);
   assign range_mask  = ({WORD_BITS{1'b1}} << lo_bit)
                      & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_bit));
   assign slot_free   = !rsp_valid_ff || rsp_port.ready;

   // Next state, RAM write and result
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      addr_in       = addr_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      res_index_in  = res_index_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      mem_wdata     = cur_word;
      req_port.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               op_in    = req_port.req_type;
               start_in = req_port.range_start;
               end_in   = req_port.range_end;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            res_index_in  = '0;
            res_status_in = STATUS_OK;
            if (op_ff == REQ_ALLOC) begin
               addr_in  = '0;
               state_in = ST_READ;
            end else if ({1'b0, first_frame} >= SPAN_W'(FRAME_COUNT)) begin
               state_in = ST_DONE;
            end else begin
               first_in = FRM_W'(first_frame);
               if (last_frame >= SPAN_W'(FRAME_COUNT)) begin
                  last_in = FRM_W'(FRAME_COUNT - 1);
               end else begin
                  last_in = FRM_W'(last_frame);
               end
               addr_in  = first_frame[FRM_W-1:BIT_W];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (op_ff == REQ_ALLOC) begin
               if (avail_word != '1) begin
                  mem_we       = 1'b1;
                  mem_wdata    = cur_word | (word_type'(1) << free_bit);
                  res_index_in = frame_wide[INDEX_W-1:0];
                  state_in     = ST_DONE;
               end else if (addr_ff == ADDR_W'(MAP_WORDS - 1)) begin
                  res_status_in = STATUS_OOM;
                  state_in      = ST_DONE;
               end else begin
                  addr_in  = addr_ff + ADDR_W'(1);
                  state_in = ST_READ;
               end
            end else begin
               mem_we    = 1'b1;
               mem_wdata = cur_word | range_mask;
               if (addr_ff == last_ff[FRM_W-1:BIT_W]) begin
                  state_in = ST_DONE;
               end else begin
                  addr_in  = addr_ff + ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = res_index_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         map_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) begin
            map_valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      addr_ff       <= addr_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      res_index_ff  <= res_index_in;
      res_status_ff <= res_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Bitmap RAM: write back, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[addr_ff] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         mem_q_ff   <= map_mem[addr_ff];
         valid_q_ff <= map_valid_ff[addr_ff];
      end
   end

   // Drive the result channel
   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.frame_index = rsp_index_ff;
   assign rsp_port.status      = rsp_status_ff;

   // Check sequencing
   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> $past(state_ff) == ST_READ)
      else $error("bitmap write without a preceding read");

   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> state_ff == ST_PREP)
      else $error("accepted request did not start setup");

   a_oom_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_OOM) |-> rsp_index_ff == '0)
      else $error("out of memory result carries a frame index");

   a_rsp_drop_on_transfer: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_port.ready))
      else $error("result dropped without a transfer");

   a_alloc_hit_done: assert property (@(posedge clock) disable iff (reset)
      (mem_we && op_ff == REQ_ALLOC) |=> (state_ff == ST_DONE && res_status_ff == STATUS_OK))
      else $error("allocation did not complete after claiming a frame");

endmodule

FILE: test/frame_grant_checker.sv
// ----------------------------------------------------------------------------
// frame_grant_checker
// Watches both channels of the frame bitmap allocator, keeps its own copy of
// the used/free map, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module frame_grant_checker (
   input  logic clock,
   input  logic reset,
   fba_req_if   req_mon,
   fba_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_count,
   output int   granted_count,
   output int   oom_count,
   output int   marked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import fba_pkg::*;

   typedef struct {
      logic [INDEX_W-1:0] frame_index;
      logic               status;
   } grant_type;

   grant_type              grant_queue[$];
   logic [FRAME_COUNT-1:0] used_frames;

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   // Apply one request to the shadow map and return the result it should give
   function automatic grant_type apply_request(input logic                   kind,
                                               input logic [BYTE_ADDR_W-1:0] first_addr,
                                               input logic [BYTE_ADDR_W-1:0] last_addr);
      grant_type              g;
      logic [BYTE_ADDR_W-1:0] span;
      longint                 first_frame;
      longint                 last_frame;
      int                     free_frame;
      g.frame_index = '0;
      g.status      = STATUS_OK;
      if (kind == REQ_MARK) begin
         // Span wraps in 32 bits; frames past the map are dropped
         span        = last_addr - first_addr;
         first_frame = first_addr >> FRAME_SHIFT;
         last_frame  = first_frame + (span >> FRAME_SHIFT);
         if (first_frame < FRAME_COUNT) begin
            if (last_frame >= FRAME_COUNT) begin
               last_frame = FRAME_COUNT - 1;
            end
            for (longint k = first_frame; k <= last_frame; k++) begin
               used_frames[k] = 1'b1;
            end
         end
      end else begin
         // First fit over the whole map
         free_frame = -1;
         for (int k = 0; k < FRAME_COUNT && free_frame < 0; k++) begin
            if (!used_frames[k]) begin
               free_frame = k;
            end
         end
         if (free_frame < 0) begin
            g.status = STATUS_OOM;
         end else begin
            used_frames[free_frame] = 1'b1;
            g.frame_index           = INDEX_W'(free_frame);
         end
      end
      return g;
   endfunction

   // Compare results first, then predict: a result never belongs to a
   // request taken at the same edge
   always @(posedge clock) begin
      grant_type want;
      if (reset) begin
         grant_queue.delete();
         used_frames   = '0;
         fail_count    = 0;
         pending_count = 0;
         granted_count = 0;
         oom_count     = 0;
         marked_count  = 0;
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (grant_queue.size() == 0) begin
               report_mismatch("result transfer with no request outstanding");
            end else begin
               want = grant_queue.pop_front();
               if (rsp_mon.frame_index !== want.frame_index) begin
                  report_mismatch($sformatf("frame_index %0d, expected %0d",
                                            rsp_mon.frame_index, want.frame_index));
               end
               if (rsp_mon.status !== want.status) begin
                  report_mismatch($sformatf("status %b, expected %b",
                                            rsp_mon.status, want.status));
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            want = apply_request(req_mon.req_type, req_mon.range_start, req_mon.range_end);
            if (req_mon.req_type == REQ_MARK) begin
               marked_count++;
            end else if (want.status == STATUS_OOM) begin
               oom_count++;
            end else begin
               granted_count++;
            end
            grant_queue.push_back(want);
         end
         pending_count = grant_queue.size();
      end
   end

endmodule

FILE: test/tb_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// tb_frame_bitmap_allocator
// Drives allocate and mark-range requests into the frame bitmap allocator
// under random backpressure; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_frame_bitmap_allocator;
   timeunit 1ns;
   timeprecision 1ps;
   import fba_pkg::*;

   localparam int RANDOM_ITEMS = 820;
   localparam int CALM_FIRST   = 300;
   localparam int CALM_LAST    = 450;
   localparam int PAUSE_AT     = 600;
   localparam int IDLE_PCT     = 24;
   localparam int TAIL_CYCLES  = 100;
   localparam int CYCLE_LIMIT  = 400000;

   logic clock;
   logic reset;
   logic calm;
   int   cycle_count;
   int   fail_count;
   int   pending_count;
   int   granted_count;
   int   oom_count;
   int   marked_count;

   fba_req_if req_if ();
   fba_rsp_if rsp_if ();

   frame_bitmap_allocator dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   frame_grant_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .granted_count (granted_count),
      .oom_count     (oom_count),
      .marked_count  (marked_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Result side backpressure, off during the calm stretch
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Hold one request until its transfer; returns right after that edge
   task automatic push_request(input logic                   kind,
                               input logic [BYTE_ADDR_W-1:0] first_addr,
                               input logic [BYTE_ADDR_W-1:0] last_addr);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.req_type    <= kind;
      req_if.range_start <= first_addr;
      req_if.range_end   <= last_addr;
      do @(posedge clock); while (req_if.ready !== 1'b1);
   endtask

   // Drop valid and hold until every result has come back
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      logic [BYTE_ADDR_W-1:0] first_addr;
      logic [BYTE_ADDR_W-1:0] last_addr;
      int                     pick;
      reset              <= 1'b1;
      calm               <= 1'b0;
      req_if.valid       <= 1'b0;
      req_if.req_type    <= REQ_ALLOC;
      req_if.range_start <= '0;
      req_if.range_end   <= '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty map, single frames, word boundaries, full words,
      // ranges past the map, wrapped ranges
      push_request(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
      push_request(REQ_MARK,  32'h0000_0000, 32'h0000_0000);
      push_request(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
      push_request(REQ_MARK,  32'h0000_2000, 32'h0000_2FFF);
      push_request(REQ_MARK,  32'h0000_5000, 32'h0000_7FFF);
      push_request(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
      push_request(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
      push_request(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
      push_request(REQ_MARK,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_request(REQ_MARK,  32'hFFFF_F000, 32'h0000_0FFF);
      push_request(REQ_MARK,  32'h0040_0000, 32'h0040_0000);
      push_request(REQ_MARK,  32'h003F_FFFF, 32'h003F_FFFF);
      push_request(REQ_MARK,  32'h003F_D000, 32'h0000_1000);
      push_request(REQ_MARK,  32'h0003_E000, 32'h0004_1FFF);
      push_request(REQ_MARK,  32'h0002_0000, 32'h0003_FFFF);
      push_request(REQ_MARK,  32'h0000_0000, 32'h0001_F000);
      push_request(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
      push_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_request(REQ_MARK,  32'h0010_0000, 32'h0010_0000);
      push_request(REQ_MARK,  32'h003F_E000, 32'hFFFF_FFFF);
      push_request(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);

      // Random: mostly allocations and short in-map ranges so the map fills
      // gradually, with ranges past the map, wrapped ranges and raw noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == CALM_FIRST) calm <= 1'b1;
         if (n == CALM_LAST)  calm <= 1'b0;
         if (n == PAUSE_AT)   drain_results();
         pick = $urandom_range(99);
         if (pick < 45) begin
            push_request(REQ_ALLOC, $urandom, $urandom);
         end else if (pick < 75) begin
            first_addr = ($urandom_range(FRAME_COUNT - 1) << FRAME_SHIFT)
                         | $urandom_range(4095);
            last_addr  = first_addr + ($urandom_range(2) << FRAME_SHIFT)
                         + $urandom_range(4095);
            push_request(REQ_MARK, first_addr, last_addr);
         end else if (pick < 85) begin
            first_addr = $urandom_range(32'hFFFF_FFFF, FRAME_COUNT << FRAME_SHIFT);
            push_request(REQ_MARK, first_addr, $urandom);
         end else if (pick < 93) begin
            first_addr = ((FRAME_COUNT - 1 - $urandom_range(7)) << FRAME_SHIFT)
                         | $urandom_range(4095);
            last_addr  = $urandom_range(first_addr - 1);
            push_request(REQ_MARK, first_addr, last_addr);
         end else begin
            push_request(REQ_MARK, $urandom, $urandom);
         end
      end

      // Fill the map completely, then run out of memory
      push_request(REQ_MARK,  32'h0000_1000, 32'h0000_0000);
      push_request(REQ_MARK,  32'h0000_0000, 32'h0000_0000);
      push_request(REQ_ALLOC, 32'h0000_0000, 32'h0000_0000);
      push_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000);
      push_request(REQ_MARK,  32'h0000_0000, 32'h003F_FFFF);
      push_request(REQ_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d requests: %0d frames granted, %0d out-of-memory replies,",
               granted_count + oom_count + marked_count, granted_count, oom_count);
      $display("%0d range marks; %0d mismatches.", marked_count, fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/fba_pkg.sv
rtl/core/fba_if.sv
rtl/core/frame_bitmap_allocator.sv
test/frame_grant_checker.sv
test/tb_frame_bitmap_allocator.sv
